[rtl/core/nnis_pkg.sv]
package nnis_pkg;

	localparam int MAX_DIM     = 256;
	localparam int DIM_W       = $clog2(MAX_DIM);
	localparam int SIZE_W      = DIM_W + 1;
	localparam int PIX_W       = 24;
	localparam int ADDR_W      = 2 * DIM_W;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

	// 2*d*src + dst stays below 2*MAX_DIM^2
	localparam int NUM_W = 2 * DIM_W + 1;
	// divisor 2*dst is at most 2*MAX_DIM
	localparam int DEN_W = DIM_W + 2;
	localparam int CNT_W = $clog2(NUM_W);

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

	typedef enum logic [1:0] {
		REG_SRC_WIDTH,
		REG_SRC_HEIGHT,
		REG_DST_WIDTH,
		REG_DST_HEIGHT
	} reg_idx_t;

	typedef struct packed {
		logic [SIZE_W-1:0] src_w;
		logic [SIZE_W-1:0] src_h;
		logic [SIZE_W-1:0] dst_w;
		logic [SIZE_W-1:0] dst_h;
	} size_t;

	typedef struct packed {
		logic [DIM_W-1:0] row;
		logic [DIM_W-1:0] col;
	} pos_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_READ,
		ST_PUT
	} state_t;

endpackage

[rtl/core/nnis_item_if.sv]
interface nnis_item_if;
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [nnis_pkg::PIX_W-1:0]   pixel_in;

	modport source (output valid, output action, output pixel_in, input ready);
	modport sink (input valid, input action, input pixel_in, output ready);
endinterface

[rtl/core/nnis_result_if.sv]
interface nnis_result_if;
	logic                         valid;
	logic                         ready;
	logic [nnis_pkg::PIX_W-1:0]   pixel_out;
	logic [nnis_pkg::DIM_W-1:0]   dest_col;
	logic [nnis_pkg::DIM_W-1:0]   dest_row;
	logic                         frame_end;

	modport source (output valid, output pixel_out, output dest_col, output dest_row,
		output frame_end, input ready);
	modport sink (input valid, input pixel_out, input dest_col, input dest_row,
		input frame_end, output ready);
endinterface

[rtl/core/nearest_neighbour_image_scaler_top.sv]
// Nearest-neighbor image scaler. Send words with action 0 to load source
// pixels in raster order into a 256x256 frame store; each word with action 1
// returns the next destination pixel in raster order, tagged with its column
// and row and with frame_end on the last pixel of the frame. The source index
// is round-half-up of d*src/dst, clamped to size-1. Sizes come from four APB
// registers (src_width 0x0, src_height 0x4, dst_width 0x8, dst_height 0xC),
// 0 acts as 1 and values above 256 as 256; write them only while idle. Loads
// stream at one per clock while no produce word is in progress. A produce word
// goes through a multiply, a bit-serial divide (17 quotient bits plus done), a
// frame store read and a load of the output register, which waits while that
// register still holds an untaken result; no new word is taken until then.
// The frame store holds no reset value: read only what was loaded.
module nearest_neighbour_image_scaler_top (
	input  logic                          clk,
	input  logic                          arst_n,
	nnis_item_if.sink                     item,
	nnis_result_if.source                 result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nnis_pkg::PADDR_W-1:0]  paddr,
	input  logic [nnis_pkg::PDATA_W-1:0]  pwdata,
	output logic [nnis_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	nnis_pkg::size_t  size;
	nnis_pkg::state_t state_q, state_nx;

	nnis_pkg::pos_t   load_pos_q, out_pos_q;
	nnis_pkg::pos_t   load_pos_nx, out_pos_nx;
	logic             out_wrap;

	// item being produced
	logic [nnis_pkg::DIM_W-1:0] dx_q, dy_q;
	logic                       last_q;

	logic                        accept, load_go, prod_go;
	logic                        div_start, div_x_done, div_y_done;
	logic [nnis_pkg::NUM_W-1:0]  num_x, num_y, quo_x, quo_y;
	logic [nnis_pkg::NUM_W-1:0]  prod_x, prod_y;
	logic [nnis_pkg::DIM_W-1:0]  sx, sy;
	logic [nnis_pkg::PIX_W-1:0]  rdata;
	logic                        rd_en, out_free, out_load;

	logic                        res_valid_q;
	logic [nnis_pkg::PIX_W-1:0]  res_pixel_q;
	logic [nnis_pkg::DIM_W-1:0]  res_col_q, res_row_q;
	logic                        res_end_q;

	// raster step; wrap flag set when the frame ends
	function automatic nnis_pkg::pos_t step_pos(
		input nnis_pkg::pos_t p,
		input logic [nnis_pkg::SIZE_W-1:0] w,
		input logic [nnis_pkg::SIZE_W-1:0] h,
		output logic wrap
	);
		nnis_pkg::pos_t n;
		n    = p;
		wrap = 1'b0;
		if (nnis_pkg::SIZE_W'(p.col) + nnis_pkg::SIZE_W'(1) >= w) begin
			n.col = '0;
			if (nnis_pkg::SIZE_W'(p.row) + nnis_pkg::SIZE_W'(1) >= h) begin
				n.row = '0;
				wrap  = 1'b1;
			end else begin
				n.row = p.row + nnis_pkg::DIM_W'(1);
			end
		end else begin
			n.col = p.col + nnis_pkg::DIM_W'(1);
		end
		return n;
	endfunction

	// index clamp to size-1
	function automatic logic [nnis_pkg::DIM_W-1:0] clamp_idx(
		input logic [nnis_pkg::NUM_W-1:0]  q,
		input logic [nnis_pkg::SIZE_W-1:0] s
	);
		logic [nnis_pkg::SIZE_W-1:0] top;
		top = s - nnis_pkg::SIZE_W'(1);
		if (q > nnis_pkg::NUM_W'(top))
			return top[nnis_pkg::DIM_W-1:0];
		return q[nnis_pkg::DIM_W-1:0];
	endfunction

	nnis_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.size    (size)
	);

	// ---- input side ----
	assign accept  = item.valid && item.ready;
	assign load_go = accept && !item.action;
	assign prod_go = accept && item.action;

	logic load_wrap_unused;
	always_comb begin
		load_pos_nx = step_pos(load_pos_q, size.src_w, size.src_h, load_wrap_unused);
		out_pos_nx  = step_pos(out_pos_q, size.dst_w, size.dst_h, out_wrap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			out_pos_q  <= '0;
		end else begin
			if (load_go)
				load_pos_q <= load_pos_nx;
			if (prod_go)
				out_pos_q <= out_pos_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (prod_go) begin
			dx_q   <= out_pos_q.col;
			dy_q   <= out_pos_q.row;
			last_q <= out_wrap;
		end
	end

	// ---- index mapping: (2*d*src + dst) / (2*dst) ----
	assign prod_x = nnis_pkg::NUM_W'(dx_q) * nnis_pkg::NUM_W'(size.src_w);
	assign prod_y = nnis_pkg::NUM_W'(dy_q) * nnis_pkg::NUM_W'(size.src_h);
	assign num_x  = {prod_x[nnis_pkg::NUM_W-2:0], 1'b0} + nnis_pkg::NUM_W'(size.dst_w);
	assign num_y  = {prod_y[nnis_pkg::NUM_W-2:0], 1'b0} + nnis_pkg::NUM_W'(size.dst_h);

	nnis_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_x),
		.den    ({size.dst_w, 1'b0}),
		.done   (div_x_done),
		.quo    (quo_x)
	);

	nnis_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_y),
		.den    ({size.dst_h, 1'b0}),
		.done   (div_y_done),
		.quo    (quo_y)
	);

	assign sx = clamp_idx(quo_x, size.src_w);
	assign sy = clamp_idx(quo_y, size.src_h);

	nnis_store u_store (
		.clk   (clk),
		.we    (load_go),
		.waddr ({load_pos_q.row, load_pos_q.col}),
		.wdata (item.pixel_in),
		.re    (rd_en),
		.raddr ({sy, sx}),
		.rdata (rdata)
	);

	// ---- sequencer ----
	assign out_free = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= nnis_pkg::ST_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx   = state_q;
		item.ready = 1'b0;
		div_start  = 1'b0;
		rd_en      = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			nnis_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid && item.action)
					state_nx = nnis_pkg::ST_MUL;
			end
			nnis_pkg::ST_MUL: begin
				div_start = 1'b1;
				state_nx  = nnis_pkg::ST_DIV;
			end
			nnis_pkg::ST_DIV: begin
				if (div_x_done && div_y_done)
					state_nx = nnis_pkg::ST_READ;
			end
			nnis_pkg::ST_READ: begin
				rd_en    = 1'b1;
				state_nx = nnis_pkg::ST_PUT;
			end
			nnis_pkg::ST_PUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_nx = nnis_pkg::ST_IDLE;
				end
			end
			default: state_nx = nnis_pkg::ST_IDLE;
		endcase
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (out_load)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_pixel_q <= rdata;
			res_col_q   <= dx_q;
			res_row_q   <= dy_q;
			res_end_q   <= last_q;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.pixel_out = res_pixel_q;
	assign result.dest_col  = res_col_q;
	assign result.dest_row  = res_row_q;
	assign result.frame_end = res_end_q;

	// ---- checks ----
	a_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nnis_pkg::ST_READ |->
			(nnis_pkg::SIZE_W'(sx) < size.src_w) && (nnis_pkg::SIZE_W'(sy) < size.src_h))
		else $error("mapped source index outside frame");

	a_div_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(div_x_done || div_y_done) |-> (state_q == nnis_pkg::ST_DIV) && div_x_done && div_y_done)
		else $error("divider done outside divide phase");

	a_put_drains: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nnis_pkg::ST_PUT && !res_valid_q |=> res_valid_q)
		else $error("result not loaded into free output register");

endmodule

[rtl/core/nnis_cfg.sv]
module nnis_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nnis_pkg::PADDR_W-1:0]  paddr,
	input  logic [nnis_pkg::PDATA_W-1:0]  pwdata,
	output logic [nnis_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output nnis_pkg::size_t               size
);

	logic [nnis_pkg::SIZE_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	nnis_pkg::reg_idx_t          idx;
	logic                        wr_en;
	logic [nnis_pkg::SIZE_W-1:0] rd_val;

	function automatic logic [nnis_pkg::SIZE_W-1:0] eff(input logic [nnis_pkg::SIZE_W-1:0] v);
		logic [nnis_pkg::SIZE_W-1:0] r;
		r = v;
		if (v == '0)
			r = nnis_pkg::SIZE_W'(1);
		else if (v > nnis_pkg::SIZE_RESET)
			r = nnis_pkg::SIZE_RESET;
		return r;
	endfunction

	assign idx    = nnis_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= nnis_pkg::SIZE_RESET;
			src_h_q <= nnis_pkg::SIZE_RESET;
			dst_w_q <= nnis_pkg::SIZE_RESET;
			dst_h_q <= nnis_pkg::SIZE_RESET;
		end else if (wr_en) begin
			case (idx)
				nnis_pkg::REG_SRC_WIDTH:  src_w_q <= pwdata[nnis_pkg::SIZE_W-1:0];
				nnis_pkg::REG_SRC_HEIGHT: src_h_q <= pwdata[nnis_pkg::SIZE_W-1:0];
				nnis_pkg::REG_DST_WIDTH:  dst_w_q <= pwdata[nnis_pkg::SIZE_W-1:0];
				nnis_pkg::REG_DST_HEIGHT: dst_h_q <= pwdata[nnis_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			nnis_pkg::REG_SRC_WIDTH:  rd_val = src_w_q;
			nnis_pkg::REG_SRC_HEIGHT: rd_val = src_h_q;
			nnis_pkg::REG_DST_WIDTH:  rd_val = dst_w_q;
			nnis_pkg::REG_DST_HEIGHT: rd_val = dst_h_q;
			default:                  rd_val = '0;
		endcase
	end

	assign prdata = nnis_pkg::PDATA_W'(rd_val);

	// out-of-range sizes: 0 acts as 1, above max acts as max
	assign size.src_w = eff(src_w_q);
	assign size.src_h = eff(src_h_q);
	assign size.dst_w = eff(dst_w_q);
	assign size.dst_h = eff(dst_h_q);

endmodule

[rtl/core/nnis_div.sv]
// restoring divider, one quotient bit per cycle
module nnis_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [nnis_pkg::NUM_W-1:0]  num,
	input  logic [nnis_pkg::DEN_W-1:0]  den,
	output logic                        done,
	output logic [nnis_pkg::NUM_W-1:0]  quo
);

	logic                        busy_q, done_q;
	logic [nnis_pkg::CNT_W-1:0]  cnt_q;
	logic [nnis_pkg::NUM_W-1:0]  num_q;
	logic [nnis_pkg::DEN_W-1:0]  den_q;
	logic [nnis_pkg::DEN_W-1:0]  rem_q;
	logic [nnis_pkg::DEN_W:0]    trial;
	logic                        fits;

	assign trial = {rem_q, num_q[nnis_pkg::NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nnis_pkg::CNT_W'(nnis_pkg::NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - nnis_pkg::CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift into the numerator register
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[nnis_pkg::NUM_W-2:0], fits};
			if (fits)
				rem_q <= nnis_pkg::DEN_W'(trial - {1'b0, den_q});
			else
				rem_q <= trial[nnis_pkg::DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

[rtl/core/nnis_store.sv]
// frame store, one write and one registered read port
module nnis_store (
	input  logic                         clk,
	input  logic                         we,
	input  logic [nnis_pkg::ADDR_W-1:0]  waddr,
	input  logic [nnis_pkg::PIX_W-1:0]   wdata,
	input  logic                         re,
	input  logic [nnis_pkg::ADDR_W-1:0]  raddr,
	output logic [nnis_pkg::PIX_W-1:0]   rdata
);

	logic [nnis_pkg::PIX_W-1:0] mem_q [0:nnis_pkg::STORE_DEPTH-1];
	logic [nnis_pkg::PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[test/nnis_tb_pkg.sv]
`timescale 1ns / 100ps
package nnis_tb_pkg;

	// action field of an item word
	typedef enum logic {
		ACT_LOAD,
		ACT_PRODUCE
	} action_t;

endpackage

[test/scaled_pixel_checker.sv]
`timescale 1ns / 100ps
module scaled_pixel_checker
	import nnis_pkg::*;
	import nnis_tb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	nnis_item_if                item,
	nnis_result_if              result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output int unsigned         mismatch_total,
	output int unsigned         words_pending
);

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [DIM_W-1:0] col;
		logic [DIM_W-1:0] row;
		logic             last;
	} scaled_pixel_t;

	logic [PIX_W-1:0]  frame_mem [STORE_DEPTH];
	logic [SIZE_W-1:0] cfg_src_w, cfg_src_h, cfg_dst_w, cfg_dst_h;
	int unsigned       load_col, load_row, out_col, out_row;
	int unsigned       bad_count = 0;
	int unsigned       words_seen = 0;
	scaled_pixel_t     pending_pixels [$];

	// 0 acts as 1, anything past MAX_DIM as MAX_DIM
	function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	// round-half-up of d*src/dst, held inside the source frame
	function automatic int unsigned nearest_src(input int unsigned d, input int unsigned src,
		input int unsigned dst);
		int unsigned s;
		s = (2 * d * src + dst) / (2 * dst);
		return (s > src - 1) ? src - 1 : s;
	endfunction

	// raster step; a position already past the sizes wraps at once
	function automatic bit step_raster(inout int unsigned col, inout int unsigned row,
		input int unsigned w, input int unsigned h);
		if (col + 1 >= w) begin
			col = 0;
			if (row + 1 >= h) begin
				row = 0;
				return 1'b1;
			end
			row = row + 1;
			return 1'b0;
		end
		col = col + 1;
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		int unsigned   sw, sh, dw, dh, sx, sy;
		scaled_pixel_t want;
		bit            wrapped;
		if (!arst_n) begin
			cfg_src_w = SIZE_RESET;
			cfg_src_h = SIZE_RESET;
			cfg_dst_w = SIZE_RESET;
			cfg_dst_h = SIZE_RESET;
			load_col = 0;
			load_row = 0;
			out_col = 0;
			out_row = 0;
			pending_pixels.delete();
			words_pending <= 0;
			mismatch_total <= bad_count;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_SRC_WIDTH:  cfg_src_w = pwdata[SIZE_W-1:0];
					REG_SRC_HEIGHT: cfg_src_h = pwdata[SIZE_W-1:0];
					REG_DST_WIDTH:  cfg_dst_w = pwdata[SIZE_W-1:0];
					REG_DST_HEIGHT: cfg_dst_h = pwdata[SIZE_W-1:0];
					default: ;
				endcase
			end

			sw = clamp_size(cfg_src_w);
			sh = clamp_size(cfg_src_h);
			dw = clamp_size(cfg_dst_w);
			dh = clamp_size(cfg_dst_h);

			// result side first: nothing accepted at this edge can already be out
			if (result.valid && result.ready) begin
				if (pending_pixels.size() == 0) begin
					if (bad_count < 10)
						$display("ERROR: word %0d unexpected: pixel %06h col %0d row %0d end %0b",
							words_seen, result.pixel_out, result.dest_col, result.dest_row,
							result.frame_end);
					bad_count++;
				end else begin
					want = pending_pixels.pop_front();
					if (result.pixel_out !== want.pixel || result.dest_col !== want.col ||
						result.dest_row !== want.row || result.frame_end !== want.last) begin
						if (bad_count < 10)
							$display("ERROR: word %0d expected pixel %06h col %0d row %0d end %0b, got pixel %06h col %0d row %0d end %0b",
								words_seen, want.pixel, want.col, want.row, want.last,
								result.pixel_out, result.dest_col, result.dest_row,
								result.frame_end);
						bad_count++;
					end
				end
				words_seen++;
			end

			if (item.valid && item.ready) begin
				if (item.action == ACT_PRODUCE) begin
					sx = nearest_src(out_col, sw, dw);
					sy = nearest_src(out_row, sh, dh);
					want.pixel = frame_mem[{sy[DIM_W-1:0], sx[DIM_W-1:0]}];
					want.col = out_col[DIM_W-1:0];
					want.row = out_row[DIM_W-1:0];
					want.last = step_raster(out_col, out_row, dw, dh);
					pending_pixels.push_back(want);
				end else begin
					frame_mem[{load_row[DIM_W-1:0], load_col[DIM_W-1:0]}] = item.pixel_in;
					wrapped = step_raster(load_col, load_row, sw, sh);
				end
			end

			words_pending <= pending_pixels.size();
			mismatch_total <= bad_count;
		end
	end

endmodule

[test/nearest_neighbour_image_scaler_top_tb.sv]
`timescale 1ns / 100ps
module nearest_neighbour_image_scaler_top_tb;
	import nnis_pkg::*;
	import nnis_tb_pkg::*;

	// idle margin after the last expected word, before the next setting
	localparam int SETTLE_CYCLES = 30;
	// long receiver hold-off so the block backs up into its input
	localparam int HOLD_OFF_CYCLES = 400;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int unsigned        mismatch_total;
	int unsigned        words_pending;

	// idling controls for sender and receiver
	bit calm = 1'b0;       // no idling on either side
	bit squeeze = 1'b0;    // ask for the long receiver hold-off
	bit squeezed = 1'b0;   // hold-off done, only once

	nnis_item_if   item_ch ();
	nnis_result_if result_ch ();

	nearest_neighbour_image_scaler_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	scaled_pixel_checker pixel_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item_ch),
		.result         (result_ch),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_total (mismatch_total),
		.words_pending  (words_pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// effective frame size as the block sees it
	function automatic int unsigned frame_dim(input logic [SIZE_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	// mostly random pixels, now and then all zeros or all ones
	function automatic logic [PIX_W-1:0] random_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom());
		endcase
	endfunction

	// source sizes stay small since every source pixel costs a load word
	function automatic logic [SIZE_W-1:0] pick_src_dim();
		case ($urandom_range(9))
			0: return '0;
			default: return SIZE_W'($urandom_range(1, 8));
		endcase
	endfunction

	// destination may be large or out of range: only produce words pay for it
	function automatic logic [SIZE_W-1:0] pick_dst_dim();
		case ($urandom_range(9))
			0: return '0;
			1: return SIZE_W'($urandom_range(200, 511));
			default: return SIZE_W'($urandom_range(1, 16));
		endcase
	endfunction

	// APB write: setup, access, then an idle state with psel low so back-to-back
	// writes never touch psel twice in one step
	task automatic write_reg(input reg_idx_t idx, input logic [SIZE_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// offer one item word; valid stays high into the next call
	task automatic send_word(input action_t act, input logic [PIX_W-1:0] pix);
		while (!calm && $urandom_range(99) < 11) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= act;
		item_ch.pixel_in <= pix;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
	endtask

	// drop valid, wait for every expected word, then let the block go idle.
	// The first edge lets the checker take in the last accepted word.
	task automatic settle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One setting: load a full source frame from position 0, then a mix of
	// produce and load words. Loads after the fill only overwrite inside the
	// frame, so no produce can reach an unloaded entry. Pad with loads so the
	// load position is back at 0 for the next setting.
	task automatic run_phase(input logic [SIZE_W-1:0] sw_raw, input logic [SIZE_W-1:0] sh_raw,
		input logic [SIZE_W-1:0] dw_raw, input logic [SIZE_W-1:0] dh_raw,
		input int unsigned mix_words, input int unsigned produce_pct);
		int unsigned frame_px;
		int unsigned loads;
		int unsigned k;
		frame_px = frame_dim(sw_raw) * frame_dim(sh_raw);
		loads = 0;
		write_reg(REG_SRC_WIDTH, sw_raw);
		write_reg(REG_SRC_HEIGHT, sh_raw);
		write_reg(REG_DST_WIDTH, dw_raw);
		write_reg(REG_DST_HEIGHT, dh_raw);
		for (k = 0; k < frame_px; k++) begin
			send_word(ACT_LOAD, random_pixel());
			loads++;
		end
		for (k = 0; k < mix_words; k++) begin
			if ($urandom_range(99) < produce_pct)
				send_word(ACT_PRODUCE, random_pixel());
			else begin
				send_word(ACT_LOAD, random_pixel());
				loads++;
			end
		end
		while (loads % frame_px != 0) begin
			send_word(ACT_LOAD, random_pixel());
			loads++;
		end
		settle();
	endtask

	// Receiver: random stalls about 11% of cycles, none while calm, and
	// one long hold-off when the stimulus asks for it.
	initial begin : result_drain
		int unsigned held;
		forever begin
			if (squeeze && !squeezed) begin
				squeezed = 1'b1;
				result_ch.ready <= 1'b0;
				for (held = 0; held < HOLD_OFF_CYCLES; held++)
					@(posedge clk);
			end else begin
				result_ch.ready <= calm || ($urandom_range(99) >= 11);
				@(posedge clk);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int unsigned n;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.action <= ACT_LOAD;
		item_ch.pixel_in <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: 3x1 source scaled up past 2x to 8x1, so the rightmost
		// destination column rounds onto index 3 and must clamp to 2.
		// Pixel extremes loaded, a full frame produced (frame end on the
		// eighth word), then one load that wraps onto (0,0) and a produce
		// that must see the new value there.
		write_reg(REG_SRC_WIDTH, 3);
		write_reg(REG_SRC_HEIGHT, 1);
		write_reg(REG_DST_WIDTH, 8);
		write_reg(REG_DST_HEIGHT, 1);
		send_word(ACT_LOAD, 24'h000000);
		send_word(ACT_LOAD, 24'hFFFFFF);
		send_word(ACT_LOAD, 24'h5A5A5A);
		for (n = 0; n < 8; n++)
			send_word(ACT_PRODUCE, random_pixel());
		send_word(ACT_LOAD, 24'hA5A5A5);
		send_word(ACT_PRODUCE, random_pixel());
		// fill the rest of the frame so loads restart at column 0
		send_word(ACT_LOAD, random_pixel());
		send_word(ACT_LOAD, random_pixel());
		settle();

		// all sizes zero act as 1x1; the output position left at column 1
		// lies past the new width and has to wrap at once
		run_phase(0, 0, 0, 0, 12, 70);
		// widest source (out-of-range value reads as 256), strong downscale
		run_phase(300, 1, 5, 3, 10, 100);

		// full 256-wide destination row, every column through 255;
		// no idling on either side for this stretch
		calm = 1'b1;
		run_phase(4, 1, 256, 2, 260, 100);
		calm = 1'b0;

		// tallest destination (511 reads as 256), every row through 255
		run_phase(1, 3, 1, 511, 262, 100);

		// produce words keep coming while the receiver holds off
		squeeze = 1'b1;
		run_phase(5, 4, 7, 6, 40, 100);

		repeat (5)
			run_phase(pick_src_dim(), pick_src_dim(), pick_dst_dim(), pick_dst_dim(), 45, 70);

		if (mismatch_total == 0 && words_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
